### rtl/core/bilinear_integer_upscaler_defines.svh
// Assertion macros shared by the bilinear upscaler modules.
`ifndef BILINEAR_INTEGER_UPSCALER_DEFINES_SVH
`define BILINEAR_INTEGER_UPSCALER_DEFINES_SVH

// The condition must hold at every clock edge out of reset.
`define BIU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold at the same edge as the antecedent.
`define BIU_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/biu_pkg.sv
// Shared constants and transfer payload types of the bilinear upscaler.
package biu_pkg;

  localparam int COORD_W = 12;
  localparam int CHAN_W = 8;
  localparam int PIXEL_W = 3 * CHAN_W;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_DIM_W = 9;
  localparam int CFG_MAG_W = 5;

  localparam int DEF_MAX_WIDTH = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_MAG = 16;

  localparam int RST_WIDTH = 160;
  localparam int RST_HEIGHT = 120;
  localparam int RST_MAG = 4;

  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAG = 2'd2;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [7:0]         write_x;
    logic [7:0]         write_y;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              out_of_range;
  } out_item_t;

endpackage

### rtl/core/biu_stream_if.sv
// Valid/ready stream channel carrying one payload per transfer.
interface biu_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/bilinear_integer_upscaler.sv
// Bilinear integer-factor image upscaler: one pixel request per clock from a
// banked frame store. A store transfer writes one source pixel and yields no
// result; a request transfer yields one interpolated pixel from the fetch and
// blend pipeline, and a new transfer is taken every clock while the result
// side keeps up. The frame store is split into four RAM banks by column and
// row parity, each with one write and one read port, which is what lets all
// four neighbors be read at once. When a result waits untaken, the whole
// pipeline holds and input ready drops until it moves. Register writes must
// be made with the pipeline empty.
module bilinear_integer_upscaler import biu_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_MAG = DEF_MAX_MAG
) (
  input  logic                  clk,
  input  logic                  rst_n,
  biu_stream_if.sink            in_chan,
  biu_stream_if.source          out_chan,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int MW = $clog2(MAX_MAG + 1);
  localparam int MB = $clog2(MAX_MAG);
  localparam int NW = (COORD_W > CHAN_W + 2 * MB) ? COORD_W : CHAN_W + 2 * MB;
  localparam int RW = NW + MB + 1;

  logic [WW-1:0]      width;
  logic [HW-1:0]      height;
  logic [MW-1:0]      mag;
  logic [RW-1:0]      recip;
  logic               en;
  logic               rd_valid;
  logic               rd_oor;
  logic [MW-1:0]      rd_fx;
  logic [MW-1:0]      rd_fy;
  logic [PIXEL_W-1:0] p00;
  logic [PIXEL_W-1:0] p10;
  logic [PIXEL_W-1:0] p01;
  logic [PIXEL_W-1:0] p11;
  logic               res_valid;
  out_item_t          res;
  in_item_t           in_item;

  assign en = !res_valid || out_chan.ready;
  assign in_chan.ready = en;
  assign in_item = in_chan.data;

  biu_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_MAG   (MAX_MAG)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (cfg_psel),
    .penable(cfg_penable),
    .pwrite (cfg_pwrite),
    .paddr  (cfg_paddr),
    .pwdata (cfg_pwdata),
    .prdata (cfg_prdata),
    .pready (cfg_pready),
    .width  (width),
    .height (height),
    .mag    (mag),
    .recip  (recip)
  );

  biu_fetch #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_MAG   (MAX_MAG)
  ) u_fetch (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_chan.valid),
    .in_item (in_item),
    .width   (width),
    .height  (height),
    .mag     (mag),
    .recip   (recip),
    .rd_valid(rd_valid),
    .rd_oor  (rd_oor),
    .rd_fx   (rd_fx),
    .rd_fy   (rd_fy),
    .p00     (p00),
    .p10     (p10),
    .p01     (p01),
    .p11     (p11)
  );

  biu_blend #(
    .MAX_MAG(MAX_MAG)
  ) u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .rd_valid (rd_valid),
    .rd_oor   (rd_oor),
    .rd_fx    (rd_fx),
    .rd_fy    (rd_fy),
    .p00      (p00),
    .p10      (p10),
    .p01      (p01),
    .p11      (p11),
    .mag      (mag),
    .recip    (recip),
    .res_valid(res_valid),
    .res      (res)
  );

  assign out_chan.valid = res_valid;
  assign out_chan.data = res;

`include "bilinear_integer_upscaler_defines.svh"

  `BIU_ASSERT_IMPLIES(a_stall_blocks_input, res_valid && !out_chan.ready, !in_chan.ready, "input taken while result stalled")
  `BIU_ASSERT_IMPLIES(a_outside_is_black, res_valid && res.out_of_range, (res.out_red == '0) && (res.out_green == '0) && (res.out_blue == '0), "pixel outside the image is not zero")

endmodule

### rtl/core/biu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module biu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/biu_cfg.sv
// Configuration registers with range clamping and the reciprocal of the magnification.
module biu_cfg import biu_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_MAG = DEF_MAX_MAG,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int MW = $clog2(MAX_MAG + 1),
  localparam int MB = $clog2(MAX_MAG),
  localparam int NW = (COORD_W > CHAN_W + 2 * MB) ? COORD_W : CHAN_W + 2 * MB,
  localparam int SH = NW + MB,
  localparam int RW = SH + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [WW-1:0]         width,
  output logic [HW-1:0]         height,
  output logic [MW-1:0]         mag,
  output logic [RW-1:0]         recip
);

  localparam int W0 = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
  localparam int H0 = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;
  localparam int M0 = (RST_MAG > MAX_MAG) ? MAX_MAG : RST_MAG;

  logic [RW-1:0] recip_tab [MAX_MAG + 1];

  // Reciprocals are rounded up so that the product gives the exact floor quotient.
  for (genvar g = 0; g <= MAX_MAG; g++) begin : g_recip
    localparam longint unsigned RV =
      ((64'd1 << SH) + longint'(g) - 64'd1) / longint'((g == 0) ? 1 : g);
    assign recip_tab[g] = RW'(RV);
  end

  logic [WW-1:0] width_r;
  logic [HW-1:0] height_r;
  logic [MW-1:0] mag_r;
  logic [RW-1:0] recip_r;

  logic                 wr_en;
  logic [1:0]           reg_idx;
  logic [CFG_DIM_W-1:0] dim_val;
  logic [CFG_MAG_W-1:0] mag_val;
  logic [WW-1:0]        width_nxt;
  logic [HW-1:0]        height_nxt;
  logic [MW-1:0]        mag_nxt;

  assign wr_en = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign dim_val = pwdata[CFG_DIM_W-1:0];
  assign mag_val = pwdata[CFG_MAG_W-1:0];

  always_comb begin
    if (dim_val == '0) begin
      width_nxt = WW'(1);
      height_nxt = HW'(1);
    end else begin
      width_nxt = (32'(dim_val) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(dim_val);
      height_nxt = (32'(dim_val) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(dim_val);
    end
    if (mag_val == '0) begin
      mag_nxt = MW'(1);
    end else begin
      mag_nxt = (32'(mag_val) > MAX_MAG) ? MW'(MAX_MAG) : MW'(mag_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WW'(W0);
      height_r <= HW'(H0);
      mag_r <= MW'(M0);
      recip_r <= recip_tab[M0];
    end else if (wr_en) begin
      case (reg_idx)
        REG_WIDTH: width_r <= width_nxt;
        REG_HEIGHT: height_r <= height_nxt;
        REG_MAG: begin
          mag_r <= mag_nxt;
          recip_r <= recip_tab[mag_nxt];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH: prdata = CFG_DATA_W'(width_r);
      REG_HEIGHT: prdata = CFG_DATA_W'(height_r);
      REG_MAG: prdata = CFG_DATA_W'(mag_r);
      default: prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign width = width_r;
  assign height = height_r;
  assign mag = mag_r;
  assign recip = recip_r;

`include "bilinear_integer_upscaler_defines.svh"

  `BIU_ASSERT_ALWAYS(a_mag_legal, (mag_r != '0) && (32'(mag_r) <= MAX_MAG), "magnification out of range")

endmodule

### rtl/core/biu_fetch.sv
// Coordinate split, range check and four-bank frame store access.
module biu_fetch import biu_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_MAG = DEF_MAX_MAG,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int MW = $clog2(MAX_MAG + 1),
  localparam int MB = $clog2(MAX_MAG),
  localparam int NW = (COORD_W > CHAN_W + 2 * MB) ? COORD_W : CHAN_W + 2 * MB,
  localparam int SH = NW + MB,
  localparam int RW = SH + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  in_item_t           in_item,
  input  logic [WW-1:0]      width,
  input  logic [HW-1:0]      height,
  input  logic [MW-1:0]      mag,
  input  logic [RW-1:0]      recip,
  output logic               rd_valid,
  output logic               rd_oor,
  output logic [MW-1:0]      rd_fx,
  output logic [MW-1:0]      rd_fy,
  output logic [PIXEL_W-1:0] p00,
  output logic [PIXEL_W-1:0] p10,
  output logic [PIXEL_W-1:0] p01,
  output logic [PIXEL_W-1:0] p11
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int HXW = (XW > 1) ? XW - 1 : 1;
  localparam int HYW = (YW > 1) ? YW - 1 : 1;
  localparam int AW = HXW + HYW;
  localparam int BANK_DEPTH = 1 << AW;
  localparam int PW = COORD_W + RW;
  localparam int LW = WW + MW;

  // Stage 1: accepted item.
  logic     s1_v_r;
  in_item_t s1_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r <= in_item;
    end
  end

  logic [PW-1:0] prod_x;
  logic [PW-1:0] prod_y;
  logic [LW-1:0] lim_x;
  logic [LW-1:0] lim_y;
  logic          oor_s1;

  assign prod_x = PW'(s1_item_r.out_x) * PW'(recip);
  assign prod_y = PW'(s1_item_r.out_y) * PW'(recip);
  assign lim_x = LW'(width) * LW'(mag);
  assign lim_y = LW'(height) * LW'(mag);
  assign oor_s1 = (32'(s1_item_r.out_x) >= 32'(lim_x)) || (32'(s1_item_r.out_y) >= 32'(lim_y));

  // Stage 2: quotients known; address generation and store writes.
  logic               s2_v_r;
  in_item_t           s2_item_r;
  logic [COORD_W-1:0] s2_qx_r;
  logic [COORD_W-1:0] s2_qy_r;
  logic               s2_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_item_r <= s1_item_r;
      s2_qx_r <= prod_x[SH +: COORD_W];
      s2_qy_r <= prod_y[SH +: COORD_W];
      s2_oor_r <= oor_s1;
    end
  end

  logic [COORD_W-1:0] mx;
  logic [COORD_W-1:0] my;
  logic [MW-1:0]      fx;
  logic [MW-1:0]      fy;
  logic               clx;
  logic               cly;
  logic [XW-1:0]      x0;
  logic [XW-1:0]      x1;
  logic [YW-1:0]      y0;
  logic [YW-1:0]      y1;
  logic [XW-1:0]      wcol;
  logic [YW-1:0]      wrow;
  logic               wok;
  logic [AW-1:0]      waddr;

  assign mx = s2_qx_r * COORD_W'(mag);
  assign my = s2_qy_r * COORD_W'(mag);
  assign fx = MW'(s2_item_r.out_x - mx);
  assign fy = MW'(s2_item_r.out_y - my);
  assign clx = ((COORD_W + 1)'(s2_qx_r) + (COORD_W + 1)'(1)) == (COORD_W + 1)'(width);
  assign cly = ((COORD_W + 1)'(s2_qy_r) + (COORD_W + 1)'(1)) == (COORD_W + 1)'(height);
  assign x0 = XW'(s2_qx_r);
  assign y0 = YW'(s2_qy_r);
  assign x1 = clx ? x0 : x0 + XW'(1);
  assign y1 = cly ? y0 : y0 + YW'(1);

  assign wcol = XW'(s2_item_r.write_x);
  assign wrow = YW'(s2_item_r.write_y);
  assign wok = en && s2_v_r && (s2_item_r.operation == OP_STORE)
            && (32'(s2_item_r.write_x) < MAX_WIDTH) && (32'(s2_item_r.write_y) < MAX_HEIGHT);
  assign waddr = {HYW'(wrow >> 1), HXW'(wcol >> 1)};

  logic [PIXEL_W-1:0] bank_rdata [4];

  // Bank index is {row parity, column parity}, so distinct neighbors never share a bank.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic XP = 1'((b % 2) != 0);
    localparam logic YP = 1'((b / 2) != 0);
    logic [XW-1:0] col;
    logic [YW-1:0] row;
    logic [AW-1:0] raddr;
    logic          we;

    assign col = (XP == x0[0]) ? x0 : x1;
    assign row = (YP == y0[0]) ? y0 : y1;
    assign raddr = {HYW'(row >> 1), HXW'(col >> 1)};
    assign we = wok && (wcol[0] == XP) && (wrow[0] == YP);

    biu_ram #(
      .WIDTH(PIXEL_W),
      .DEPTH(BANK_DEPTH)
    ) u_bank (
      .clk  (clk),
      .we   (we),
      .waddr(waddr),
      .wdata({s2_item_r.red, s2_item_r.green, s2_item_r.blue}),
      .re   (en),
      .raddr(raddr),
      .rdata(bank_rdata[b])
    );
  end

  // Stage 3: bank data returns and is routed to the four neighbors.
  logic          s3_v_r;
  logic          s3_oor_r;
  logic [MW-1:0] s3_fx_r;
  logic [MW-1:0] s3_fy_r;
  logic          s3_x0p_r;
  logic          s3_y0p_r;
  logic          s3_clx_r;
  logic          s3_cly_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r && (s2_item_r.operation == OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_oor_r <= s2_oor_r;
      s3_fx_r <= fx;
      s3_fy_r <= fy;
      s3_x0p_r <= x0[0];
      s3_y0p_r <= y0[0];
      s3_clx_r <= clx;
      s3_cly_r <= cly;
    end
  end

  logic x1p;
  logic y1p;

  assign x1p = s3_clx_r ? s3_x0p_r : !s3_x0p_r;
  assign y1p = s3_cly_r ? s3_y0p_r : !s3_y0p_r;

  assign p00 = bank_rdata[{s3_y0p_r, s3_x0p_r}];
  assign p10 = bank_rdata[{s3_y0p_r, x1p}];
  assign p01 = bank_rdata[{y1p, s3_x0p_r}];
  assign p11 = bank_rdata[{y1p, x1p}];

  assign rd_valid = s3_v_r;
  assign rd_oor = s3_oor_r;
  assign rd_fx = s3_fx_r;
  assign rd_fy = s3_fy_r;

`include "bilinear_integer_upscaler_defines.svh"

  `BIU_ASSERT_IMPLIES(a_col_inside, s2_v_r && (s2_item_r.operation == OP_READ) && !s2_oor_r, 32'(s2_qx_r) < 32'(width), "column quotient outside the image")
  `BIU_ASSERT_IMPLIES(a_frac_below_mag, s2_v_r && (s2_item_r.operation == OP_READ) && !s2_oor_r, (fx < mag) && (fy < mag), "fraction not below magnification")

endmodule

### rtl/core/biu_blend.sv
// Weight generation, weighted sum and normalization by the squared magnification.
module biu_blend import biu_pkg::*; #(
  parameter int MAX_MAG = DEF_MAX_MAG,
  localparam int MW = $clog2(MAX_MAG + 1),
  localparam int MB = $clog2(MAX_MAG),
  localparam int NW = (COORD_W > CHAN_W + 2 * MB) ? COORD_W : CHAN_W + 2 * MB,
  localparam int SH = NW + MB,
  localparam int RW = SH + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               rd_valid,
  input  logic               rd_oor,
  input  logic [MW-1:0]      rd_fx,
  input  logic [MW-1:0]      rd_fy,
  input  logic [PIXEL_W-1:0] p00,
  input  logic [PIXEL_W-1:0] p10,
  input  logic [PIXEL_W-1:0] p01,
  input  logic [PIXEL_W-1:0] p11,
  input  logic [MW-1:0]      mag,
  input  logic [RW-1:0]      recip,
  output logic               res_valid,
  output out_item_t          res
);

  localparam int WTW = 2 * MW;
  localparam int PRW = CHAN_W + WTW;
  localparam int SW = PRW + 2;
  localparam int QW = NW + RW;

  logic [MW-1:0] gx;
  logic [MW-1:0] gy;

  assign gx = mag - rd_fx;
  assign gy = mag - rd_fy;

  // Stage 4: corner weights in units of one over the squared magnification.
  logic               b1_v_r;
  logic               b1_oor_r;
  logic [WTW-1:0]     b1_wt_r [4];
  logic [PIXEL_W-1:0] b1_px_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      b1_oor_r <= rd_oor;
      b1_wt_r[0] <= WTW'(gx) * WTW'(gy);
      b1_wt_r[1] <= WTW'(rd_fx) * WTW'(gy);
      b1_wt_r[2] <= WTW'(gx) * WTW'(rd_fy);
      b1_wt_r[3] <= WTW'(rd_fx) * WTW'(rd_fy);
      b1_px_r[0] <= p00;
      b1_px_r[1] <= p10;
      b1_px_r[2] <= p01;
      b1_px_r[3] <= p11;
    end
  end

  // Stage 5: one product per channel and corner.
  logic           b2_v_r;
  logic           b2_oor_r;
  logic [PRW-1:0] b2_prod_r [3][4];

  always_ff @(posedge clk) begin
    if (en) begin
      b2_oor_r <= b1_oor_r;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) begin
          b2_prod_r[c][k] <= PRW'(b1_px_r[k][CHAN_W * (2 - c) +: CHAN_W]) * PRW'(b1_wt_r[k]);
        end
      end
    end
  end

  // Stage 6: weighted sums.
  logic          b3_v_r;
  logic          b3_oor_r;
  logic [NW-1:0] b3_sum_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      b3_oor_r <= b2_oor_r;
      for (int c = 0; c < 3; c++) begin
        b3_sum_r[c] <= NW'(SW'(b2_prod_r[c][0]) + SW'(b2_prod_r[c][1])
                         + SW'(b2_prod_r[c][2]) + SW'(b2_prod_r[c][3]));
      end
    end
  end

  // Stages 7 and 8: two exact floor divisions by the magnification.
  logic          b4_v_r;
  logic          b4_oor_r;
  logic [NW-1:0] b4_q_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      b4_oor_r <= b3_oor_r;
      for (int c = 0; c < 3; c++) begin
        b4_q_r[c] <= NW'((QW'(b3_sum_r[c]) * QW'(recip)) >> SH);
      end
    end
  end

  logic              b5_v_r;
  logic              b5_oor_r;
  logic [CHAN_W-1:0] b5_ch_r [3];
  logic [QW-1:0]     q2 [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q2[c] = QW'(b4_q_r[c]) * QW'(recip);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b5_oor_r <= b4_oor_r;
      for (int c = 0; c < 3; c++) begin
        b5_ch_r[c] <= b4_oor_r ? '0 : q2[c][SH +: CHAN_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      b4_v_r <= 1'b0;
      b5_v_r <= 1'b0;
    end else if (en) begin
      b1_v_r <= rd_valid;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
      b4_v_r <= b3_v_r;
      b5_v_r <= b4_v_r;
    end
  end

  assign res_valid = b5_v_r;
  assign res.out_red = b5_ch_r[0];
  assign res.out_green = b5_ch_r[1];
  assign res.out_blue = b5_ch_r[2];
  assign res.out_of_range = b5_oor_r;

endmodule
